// ----- hw/rtl/gtdc_pkg.sv -----
// shared constants and types of the gray threshold dark classifier
package gtdc_pkg;

	// default width of the per-image pixel counters
	localparam int PIXEL_COUNT_BITS = 25;

	// pixel component and gray level width
	localparam int COLOR_BITS = 8;
	localparam int PERCENT_BITS = 7;

	// configuration port
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS = 8;
	localparam logic [CFG_INDEX_BITS-1:0] REG_GRAY_THRESHOLD = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PERCENT_THRESHOLD = 1'b1;

	localparam logic [COLOR_BITS-1:0] GRAY_THRESHOLD_RESET = 8'd128;
	localparam logic [PERCENT_BITS-1:0] PERCENT_THRESHOLD_RESET = 7'd50;

	// luma weights in hundredths, weighted sum is at most 25500
	localparam int SUM_BITS = 15;
	localparam logic [SUM_BITS-1:0] WEIGHT_RED = 15'd30;
	localparam logic [SUM_BITS-1:0] WEIGHT_GREEN = 15'd59;
	localparam logic [SUM_BITS-1:0] WEIGHT_BLUE = 15'd11;

	// divide by 100 as multiply by ceil(2^19 / 100), exact for sums up to 25500
	localparam int RECIP_BITS = 13;
	localparam logic [RECIP_BITS-1:0] RECIP_100 = 13'd5243;
	localparam int DIV_SHIFT = 19;
	localparam int QUOT_PROD_BITS = SUM_BITS + RECIP_BITS;

	// full scale of the percentage comparison
	localparam int PERCENT_FULL = 100;

	// per-stage pipeline control
	typedef struct packed {
		logic adv;
		logic vld;
	} stage_ctrl_t;

endpackage

// ----- hw/rtl/gtdc_luma.sv -----
// weighted gray level and binarization, two pipeline stages
module gtdc_luma (
	input  logic                                clk,
	input  gtdc_pkg::stage_ctrl_t               ctrl_s1,
	input  gtdc_pkg::stage_ctrl_t               ctrl_s2,
	input  logic [gtdc_pkg::COLOR_BITS-1:0]     blue_s1,
	input  logic [gtdc_pkg::COLOR_BITS-1:0]     green_s1,
	input  logic [gtdc_pkg::COLOR_BITS-1:0]     red_s1,
	input  logic                                last_s1,
	input  logic [gtdc_pkg::COLOR_BITS-1:0]     gray_threshold,
	output logic [gtdc_pkg::COLOR_BITS-1:0]     gray_s3,
	output logic                                bit_s3,
	output logic                                last_s3
);

	logic [gtdc_pkg::SUM_BITS-1:0]       sum_s2;
	logic                                last_s2;
	logic [gtdc_pkg::QUOT_PROD_BITS-1:0] quot_prod;
	logic [gtdc_pkg::COLOR_BITS-1:0]     gray;

	// weights are constants, so these reduce to shift-add trees
	always_ff @(posedge clk) begin
		if (ctrl_s1.adv && ctrl_s1.vld) begin
			sum_s2 <= gtdc_pkg::SUM_BITS'(red_s1) * gtdc_pkg::WEIGHT_RED
				+ gtdc_pkg::SUM_BITS'(green_s1) * gtdc_pkg::WEIGHT_GREEN
				+ gtdc_pkg::SUM_BITS'(blue_s1) * gtdc_pkg::WEIGHT_BLUE;
			last_s2 <= last_s1;
		end
	end

	assign quot_prod = gtdc_pkg::QUOT_PROD_BITS'(sum_s2)
		* gtdc_pkg::QUOT_PROD_BITS'(gtdc_pkg::RECIP_100);
	assign gray = quot_prod[gtdc_pkg::DIV_SHIFT +: gtdc_pkg::COLOR_BITS];

	always_ff @(posedge clk) begin
		if (ctrl_s2.adv && ctrl_s2.vld) begin
			gray_s3 <= gray;
			bit_s3  <= (gray > gray_threshold);
			last_s3 <= last_s2;
		end
	end

endmodule

// ----- hw/rtl/gtdc_tally.sv -----
// per-image black and total pixel counters with saturation
module gtdc_tally #(
	parameter int PIXEL_COUNT_BITS = gtdc_pkg::PIXEL_COUNT_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  gtdc_pkg::stage_ctrl_t           ctrl_s3,
	input  logic [gtdc_pkg::COLOR_BITS-1:0] gray_s3,
	input  logic                            bit_s3,
	input  logic                            last_s3,
	output logic [gtdc_pkg::COLOR_BITS-1:0] gray_s4,
	output logic                            bit_s4,
	output logic                            last_s4,
	output logic [PIXEL_COUNT_BITS-1:0]     black_s4,
	output logic [PIXEL_COUNT_BITS-1:0]     total_s4
);

	logic [PIXEL_COUNT_BITS-1:0] black_q;
	logic [PIXEL_COUNT_BITS-1:0] total_q;
	logic [PIXEL_COUNT_BITS-1:0] black_nxt;
	logic [PIXEL_COUNT_BITS-1:0] total_nxt;

	// counts include the current pixel, stuck at all ones
	always_comb begin
		total_nxt = (&total_q) ? total_q : total_q + PIXEL_COUNT_BITS'(1);
		black_nxt = black_q;
		if (!bit_s3 && !(&black_q)) begin
			black_nxt = black_q + PIXEL_COUNT_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			black_q <= '0;
			total_q <= '0;
		end else if (ctrl_s3.adv && ctrl_s3.vld) begin
			if (last_s3) begin
				black_q <= '0;
				total_q <= '0;
			end else begin
				black_q <= black_nxt;
				total_q <= total_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_s3.adv && ctrl_s3.vld) begin
			gray_s4  <= gray_s3;
			bit_s4   <= bit_s3;
			last_s4  <= last_s3;
			black_s4 <= black_nxt;
			total_s4 <= total_nxt;
		end
	end

endmodule

// ----- hw/rtl/gtdc_verdict.sv -----
// dark-image verdict and result register
module gtdc_verdict #(
	parameter int PIXEL_COUNT_BITS = gtdc_pkg::PIXEL_COUNT_BITS
) (
	input  logic                              clk,
	input  gtdc_pkg::stage_ctrl_t             ctrl_s4,
	input  gtdc_pkg::stage_ctrl_t             ctrl_s5,
	input  logic [gtdc_pkg::COLOR_BITS-1:0]   gray_s4,
	input  logic                              bit_s4,
	input  logic                              last_s4,
	input  logic [PIXEL_COUNT_BITS-1:0]       black_s4,
	input  logic [PIXEL_COUNT_BITS-1:0]       total_s4,
	input  logic [gtdc_pkg::PERCENT_BITS-1:0] percent_threshold,
	output logic [gtdc_pkg::COLOR_BITS-1:0]   gray_s6,
	output logic                              bit_s6,
	output logic                              last_s6,
	output logic                              dark_s6
);

	localparam int PROD_BITS = PIXEL_COUNT_BITS + gtdc_pkg::PERCENT_BITS;
	localparam logic [PROD_BITS-1:0] PERCENT_SCALE = PROD_BITS'(gtdc_pkg::PERCENT_FULL);

	logic [PROD_BITS-1:0]              black_x100_s5;
	logic [PROD_BITS-1:0]              limit_s5;
	logic [gtdc_pkg::COLOR_BITS-1:0]   gray_s5;
	logic                              bit_s5;
	logic                              last_s5;

	always_ff @(posedge clk) begin
		if (ctrl_s4.adv && ctrl_s4.vld) begin
			black_x100_s5 <= PROD_BITS'(black_s4) * PERCENT_SCALE;
			limit_s5      <= PROD_BITS'(percent_threshold) * PROD_BITS'(total_s4);
			gray_s5       <= gray_s4;
			bit_s5        <= bit_s4;
			last_s5       <= last_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_s5.adv && ctrl_s5.vld) begin
			gray_s6 <= gray_s5;
			bit_s6  <= bit_s5;
			last_s6 <= last_s5;
			dark_s6 <= last_s5 && (black_x100_s5 > limit_s5);
		end
	end

endmodule

// ----- hw/rtl/gray_threshold_dark_classifier.sv -----
// top level of the gray threshold dark classifier
//
// input channel: one pixel per transaction (blue, green, red, last_pixel) on
// in_valid/in_ready. output channel: one result per pixel (gray_level,
// pixel_bit, image_end, nearly_black) on out_valid/out_ready, in input order.
// gray_level = floor((30*red + 59*green + 11*blue) / 100); pixel_bit is 1 when
// gray_level exceeds gray_threshold, otherwise the pixel counts as black.
// on the transaction with last_pixel set, image_end is 1 and nearly_black is
// 1 when black*100 > percent_threshold*total, counts taken with that pixel
// included; both counters then restart for the next image. counters saturate
// at 2^PIXEL_COUNT_BITS - 1.
// throughput: one pixel per cycle while the output is not stalled. a pixel's
// result passes the six register stages (input, weighted sum, gray/threshold,
// counters, products, result) and shows on out_valid from the result stage.
// when the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes and in_ready drops; otherwise in_ready stays high.
// reset clears all stage valids, the counters and restores the register
// defaults (gray_threshold 128, percent_threshold 50). configuration writes
// take effect at the next edge and belong between images or while idle.
module gray_threshold_dark_classifier #(
	parameter int PIXEL_COUNT_BITS = gtdc_pkg::PIXEL_COUNT_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_write,
	input  logic [gtdc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [gtdc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	// pixel input
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [gtdc_pkg::COLOR_BITS-1:0]     blue,
	input  logic [gtdc_pkg::COLOR_BITS-1:0]     green,
	input  logic [gtdc_pkg::COLOR_BITS-1:0]     red,
	input  logic                                last_pixel,
	// result output
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [gtdc_pkg::COLOR_BITS-1:0]     gray_level,
	output logic                                pixel_bit,
	output logic                                image_end,
	output logic                                nearly_black
);

	// configuration registers
	logic [gtdc_pkg::COLOR_BITS-1:0]   gray_threshold_q;
	logic [gtdc_pkg::PERCENT_BITS-1:0] percent_threshold_q;

	// pipeline control
	logic adv;
	logic vld_s1;
	logic vld_s2;
	logic vld_s3;
	logic vld_s4;
	logic vld_s5;
	logic out_valid_q;

	// input register
	logic [gtdc_pkg::COLOR_BITS-1:0] blue_s1;
	logic [gtdc_pkg::COLOR_BITS-1:0] green_s1;
	logic [gtdc_pkg::COLOR_BITS-1:0] red_s1;
	logic                            last_s1;

	// stage payloads
	logic [gtdc_pkg::COLOR_BITS-1:0] gray_s3;
	logic                            bit_s3;
	logic                            last_s3;
	logic [gtdc_pkg::COLOR_BITS-1:0] gray_s4;
	logic                            bit_s4;
	logic                            last_s4;
	logic [PIXEL_COUNT_BITS-1:0]     black_s4;
	logic [PIXEL_COUNT_BITS-1:0]     total_s4;
	logic [gtdc_pkg::COLOR_BITS-1:0] gray_s6;
	logic                            bit_s6;
	logic                            last_s6;
	logic                            dark_s6;

	gtdc_pkg::stage_ctrl_t ctrl_s1;
	gtdc_pkg::stage_ctrl_t ctrl_s2;
	gtdc_pkg::stage_ctrl_t ctrl_s3;
	gtdc_pkg::stage_ctrl_t ctrl_s4;
	gtdc_pkg::stage_ctrl_t ctrl_s5;

	// register writes, the index space is fully decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gray_threshold_q    <= gtdc_pkg::GRAY_THRESHOLD_RESET;
			percent_threshold_q <= gtdc_pkg::PERCENT_THRESHOLD_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				gtdc_pkg::REG_GRAY_THRESHOLD: begin
					gray_threshold_q <= cfg_data[gtdc_pkg::COLOR_BITS-1:0];
				end
				gtdc_pkg::REG_PERCENT_THRESHOLD: begin
					percent_threshold_q <= cfg_data[gtdc_pkg::PERCENT_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// whole pipeline moves unless a finished result is stuck at the output
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1      <= in_valid;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			vld_s5      <= vld_s4;
			out_valid_q <= vld_s5;
		end
	end

	// input register, loaded only on an accepted transaction
	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			blue_s1  <= blue;
			green_s1 <= green;
			red_s1   <= red;
			last_s1  <= last_pixel;
		end
	end

	assign ctrl_s1 = '{adv: adv, vld: vld_s1};
	assign ctrl_s2 = '{adv: adv, vld: vld_s2};
	assign ctrl_s3 = '{adv: adv, vld: vld_s3};
	assign ctrl_s4 = '{adv: adv, vld: vld_s4};
	assign ctrl_s5 = '{adv: adv, vld: vld_s5};

	// weighted sum, divide by 100, threshold
	gtdc_luma u_luma (
		.clk            (clk),
		.ctrl_s1        (ctrl_s1),
		.ctrl_s2        (ctrl_s2),
		.blue_s1        (blue_s1),
		.green_s1       (green_s1),
		.red_s1         (red_s1),
		.last_s1        (last_s1),
		.gray_threshold (gray_threshold_q),
		.gray_s3        (gray_s3),
		.bit_s3         (bit_s3),
		.last_s3        (last_s3)
	);

	// per-image counters, cleared after the last pixel
	gtdc_tally #(
		.PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
	) u_tally (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl_s3  (ctrl_s3),
		.gray_s3  (gray_s3),
		.bit_s3   (bit_s3),
		.last_s3  (last_s3),
		.gray_s4  (gray_s4),
		.bit_s4   (bit_s4),
		.last_s4  (last_s4),
		.black_s4 (black_s4),
		.total_s4 (total_s4)
	);

	// percentage compare and result register
	gtdc_verdict #(
		.PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
	) u_verdict (
		.clk               (clk),
		.ctrl_s4           (ctrl_s4),
		.ctrl_s5           (ctrl_s5),
		.gray_s4           (gray_s4),
		.bit_s4            (bit_s4),
		.last_s4           (last_s4),
		.black_s4          (black_s4),
		.total_s4          (total_s4),
		.percent_threshold (percent_threshold_q),
		.gray_s6           (gray_s6),
		.bit_s6            (bit_s6),
		.last_s6           (last_s6),
		.dark_s6           (dark_s6)
	);

	assign out_valid    = out_valid_q;
	assign gray_level   = gray_s6;
	assign pixel_bit    = bit_s6;
	assign image_end    = last_s6;
	assign nearly_black = dark_s6;

endmodule

// ----- hw/rtl/gtdc_checker.sv -----
// port-level checker of the gray threshold dark classifier and its bind
module gtdc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [gtdc_pkg::COLOR_BITS-1:0]     gray_level,
	input logic                                pixel_bit,
	input logic                                image_end,
	input logic                                nearly_black
);

	// a stalled result holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(gray_level)
			&& $stable(pixel_bit) && $stable(image_end) && $stable(nearly_black))
		else $error("stalled result changed");

	// the verdict only rides on the transaction that closes an image
	a_verdict_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !image_end |-> !nearly_black)
		else $error("nearly_black set on a pixel that does not close an image");

	// input is never held off while the output side is empty
	a_no_idle_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("in_ready low with no result waiting");

	// input stall only comes from a stuck result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

endmodule

bind gray_threshold_dark_classifier gtdc_checker u_gtdc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.gray_level   (gray_level),
	.pixel_bit    (pixel_bit),
	.image_end    (image_end),
	.nearly_black (nearly_black)
);
